@@ sv/avsg_pkg.sv @@
// ----------------------------------------------------------------------------
// avsg_pkg
// Shared types, constants and helpers of the arc vertex strip generator.
// ----------------------------------------------------------------------------
package avsg_pkg;

  localparam int AngleBitsDef   = 16;
  localparam int CordicIterDef  = 16;
  localparam int MaxSegments    = 31;

  // cordic start vector, gain constant in q2.30
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [36:0] RoundHalf  = 37'sd16384;

  typedef enum logic [1:0] {
    MUL_RIN  = 2'd0,
    MUL_ROUT = 2'd1,
    MUL_ROT1 = 2'd2,
    MUL_ROT2 = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     cor_init;
    logic     cor_sel_start;
    logic     cor_step;
    logic     store_step;
    logic     store_start;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     emit;
    logic     emit_outer;
    logic     rot_mid;
    logic     rot_end;
  } avsg_cmd_t;

  typedef struct packed {
    logic div_last;
    logic cor_last;
    logic pair_last;
    logic out_free;
  } avsg_stat_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [33:0] atan_f(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      5'd20:   v = 34'sd652;
      5'd21:   v = 34'sd326;
      5'd22:   v = 34'sd163;
      5'd23:   v = 34'sd81;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // clamp to the signed 16 bit range, kept 17 bits wide
  function automatic logic signed [16:0] sat16(input logic signed [36:0] v);
    logic signed [16:0] r;
    if (v > 37'sd32767) begin
      r = 17'sd32767;
    end else if (v < -37'sd32768) begin
      r = -17'sd32768;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  // q1.15 product rounding: add half, floor shift
  function automatic logic signed [36:0] rnd15(input logic signed [36:0] v);
    return (v + RoundHalf) >>> 15;
  endfunction

endpackage

@@ sv/avsg_dp.sv @@
// ----------------------------------------------------------------------------
// avsg_dp
// Datapath: request registers, step divider, shared cordic, multiplier pair,
// rotation recurrence and output word register.
// ----------------------------------------------------------------------------
module avsg_dp #(
  parameter int ANGLE_BITS        = avsg_pkg::AngleBitsDef,
  parameter int CORDIC_ITERATIONS = avsg_pkg::CordicIterDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  avsg_pkg::avsg_cmd_t      cmd_i,
  output avsg_pkg::avsg_stat_t     stat_o,
  input  logic signed [15:0]       center_x_i,
  input  logic signed [15:0]       center_y_i,
  input  logic [15:0]              start_angle_i,
  input  logic [16:0]              sweep_angle_i,
  input  logic [15:0]              radius_i,
  input  logic [15:0]              thickness_i,
  input  logic [4:0]               segment_count_i,
  input  logic                     fan_mode_i,
  input  logic [31:0]              color_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [15:0]       vertex_x_o,
  output logic signed [15:0]       vertex_y_o,
  output logic [31:0]              vertex_color_o,
  output logic                     last_vertex_o
);
  import avsg_pkg::*;

  localparam int AW  = ANGLE_BITS + 17;
  localparam int QW  = ANGLE_BITS + 1;
  localparam int DCW = $clog2(QW);
  localparam int CCW = $clog2(CORDIC_ITERATIONS);

  logic signed [15:0]      cx_q, cy_q;
  logic [31:0]             color_q;
  logic [4:0]              seg_q, pt_q;
  logic signed [17:0]      rin_q, rout_q;
  logic [ANGLE_BITS-1:0]   start_q;
  logic [QW-1:0]           quo_q;
  logic [4:0]              rem_q;
  logic [DCW-1:0]          dcnt_q;
  logic signed [33:0]      x_q, y_q, z_q;
  logic [CCW-1:0]          ccnt_q;
  logic [1:0]              quad_q;
  logic signed [16:0]      ss_q, cs_q, sa_q, ca_q, ns_q;
  logic signed [34:0]      p0_q, p1_q;
  logic                    ov_q;

  // request decode
  logic [4:0]              seg_c;
  logic signed [17:0]      half_c, rad_c;
  logic [AW-1:0]           start_w, sweep_w;

  always_comb begin
    seg_c = (segment_count_i == 5'd0) ? 5'd1 : segment_count_i;
    if (seg_c > 5'(MaxSegments)) begin
      seg_c = 5'(MaxSegments);
    end
    half_c  = 18'(thickness_i[15:1]);
    rad_c   = 18'(radius_i);
    start_w = (AW'(start_angle_i) << ANGLE_BITS) >> 16;
    sweep_w = (AW'(sweep_angle_i) << ANGLE_BITS) >> 16;
  end

  // divider step
  logic [5:0] trial_c;
  logic       ge_c;
  assign trial_c = {rem_q, quo_q[QW-1]};
  assign ge_c    = trial_c >= {1'b0, seg_q};

  // cordic
  logic [ANGLE_BITS-1:0]  ang_c;
  logic signed [33:0]     dx_c, dy_c, at_c;
  logic signed [16:0]     cr_c, sr_c, c_out, s_out;

  always_comb begin
    ang_c = cmd_i.cor_sel_start ? start_q : quo_q[ANGLE_BITS-1:0];
    dx_c  = y_q >>> ccnt_q;
    dy_c  = x_q >>> ccnt_q;
    at_c  = atan_f(5'(ccnt_q));
    cr_c  = sat16(rnd15(37'(x_q)));
    sr_c  = sat16(rnd15(37'(y_q)));
    case (quad_q)
      2'd0:    begin c_out = cr_c;  s_out = sr_c;  end
      2'd1:    begin c_out = -sr_c; s_out = cr_c;  end
      2'd2:    begin c_out = -cr_c; s_out = -sr_c; end
      default: begin c_out = sr_c;  s_out = -cr_c; end
    endcase
  end

  // multiplier operand selection
  logic signed [17:0] a0_c, a1_c;
  logic signed [16:0] b0_c, b1_c;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RIN:  begin a0_c = rin_q;       b0_c = ca_q; a1_c = rin_q;       b1_c = sa_q; end
      MUL_ROUT: begin a0_c = rout_q;      b0_c = ca_q; a1_c = rout_q;      b1_c = sa_q; end
      MUL_ROT1: begin a0_c = 18'(sa_q);   b0_c = cs_q; a1_c = 18'(ca_q);   b1_c = ss_q; end
      MUL_ROT2: begin a0_c = 18'(ca_q);   b0_c = cs_q; a1_c = 18'(sa_q);   b1_c = ss_q; end
      default:  begin a0_c = rin_q;       b0_c = ca_q; a1_c = rin_q;       b1_c = sa_q; end
    endcase
  end

  logic signed [36:0] vx_c, vy_c, rsum_c, rdiff_c;
  assign vx_c    = 37'(cx_q) + rnd15(37'(p0_q));
  assign vy_c    = 37'(cy_q) + rnd15(37'(p1_q));
  assign rsum_c  = rnd15(37'(p0_q) + 37'(p1_q));
  assign rdiff_c = rnd15(37'(p0_q) - 37'(p1_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      color_q <= color_i;
      seg_q   <= seg_c;
      start_q <= start_w[ANGLE_BITS-1:0];
      quo_q   <= sweep_w[QW-1:0];
      rem_q   <= 5'd0;
      rin_q   <= fan_mode_i ? 18'sd0 : rad_c - half_c;
      rout_q  <= fan_mode_i ? rad_c  : rad_c + half_c;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge_c ? 5'(trial_c - {1'b0, seg_q}) : trial_c[4:0];
      quo_q <= {quo_q[QW-2:0], ge_c};
    end
    if (cmd_i.cor_init) begin
      quad_q <= ang_c[ANGLE_BITS-1 -: 2];
      x_q    <= CordicGain;
      y_q    <= 34'sd0;
      z_q    <= 34'(ang_c[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    end else if (cmd_i.cor_step) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx_c;
        y_q <= y_q + dy_c;
        z_q <= z_q - at_c;
      end else begin
        x_q <= x_q + dx_c;
        y_q <= y_q - dy_c;
        z_q <= z_q + at_c;
      end
    end
    if (cmd_i.store_step) begin
      ss_q <= s_out;
      cs_q <= c_out;
    end
    if (cmd_i.store_start) begin
      sa_q <= s_out;
      ca_q <= c_out;
    end
    if (cmd_i.mul_en) begin
      p0_q <= a0_c * b0_c;
      p1_q <= a1_c * b1_c;
    end
    if (cmd_i.rot_mid) begin
      ns_q <= sat16(rsum_c);
    end
    if (cmd_i.rot_end) begin
      ca_q <= sat16(rdiff_c);
      sa_q <= ns_q;
    end
    if (cmd_i.emit) begin
      vertex_x_o     <= 16'(sat16(vx_c));
      vertex_y_o     <= 16'(sat16(vy_c));
      vertex_color_o <= color_q;
      last_vertex_o  <= cmd_i.emit_outer && (pt_q == seg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      ccnt_q <= '0;
      pt_q   <= 5'd0;
      ov_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.cor_init) begin
        ccnt_q <= '0;
      end else if (cmd_i.cor_step) begin
        ccnt_q <= ccnt_q + 1'b1;
      end
      if (cmd_i.store_start) begin
        pt_q <= 5'd0;
      end else if (cmd_i.rot_end) begin
        pt_q <= pt_q + 5'd1;
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign stat_o.div_last  = (dcnt_q == DCW'(QW - 1));
  assign stat_o.cor_last  = (ccnt_q == CCW'(CORDIC_ITERATIONS - 1));
  assign stat_o.pair_last = (pt_q == seg_q);
  assign stat_o.out_free  = !ov_q || !out_stall_i;

endmodule

@@ sv/avsg_ctrl.sv @@
// ----------------------------------------------------------------------------
// avsg_ctrl
// Sequencer: divide, two cordic runs, then per arc point two vertices and,
// but for the final point, a rotation update.
// ----------------------------------------------------------------------------
module avsg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  idle_o,
  input  avsg_pkg::avsg_stat_t  stat_i,
  output avsg_pkg::avsg_cmd_t   cmd_o
);
  import avsg_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DIV      = 14'b00000000000010,
    S_CI_STEP  = 14'b00000000000100,
    S_CR_STEP  = 14'b00000000001000,
    S_CI_START = 14'b00000000010000,
    S_CR_START = 14'b00000000100000,
    S_STORE    = 14'b00000001000000,
    S_MUL_A    = 14'b00000010000000,
    S_EMIT_A   = 14'b00000100000000,
    S_MUL_B    = 14'b00001000000000,
    S_EMIT_B   = 14'b00010000000000,
    S_ROT1     = 14'b00100000000000,
    S_ROT2     = 14'b01000000000000,
    S_ROT3     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_CI_STEP;
      end
      S_CI_STEP: begin
        cmd_o.cor_init = 1'b1;
        state_d        = S_CR_STEP;
      end
      S_CR_STEP: begin
        cmd_o.cor_step = 1'b1;
        if (stat_i.cor_last) state_d = S_CI_START;
      end
      S_CI_START: begin
        // step result is final here, capture it while restarting
        cmd_o.store_step    = 1'b1;
        cmd_o.cor_init      = 1'b1;
        cmd_o.cor_sel_start = 1'b1;
        state_d             = S_CR_START;
      end
      S_CR_START: begin
        cmd_o.cor_step      = 1'b1;
        cmd_o.cor_sel_start = 1'b1;
        if (stat_i.cor_last) state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.store_start = 1'b1;
        state_d           = S_MUL_A;
      end
      S_MUL_A: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RIN;
        state_d       = S_EMIT_A;
      end
      S_EMIT_A: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_MUL_B;
        end
      end
      S_MUL_B: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ROUT;
        state_d       = S_EMIT_B;
      end
      S_EMIT_B: begin
        if (stat_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_outer = 1'b1;
          state_d          = stat_i.pair_last ? S_IDLE : S_ROT1;
        end
      end
      S_ROT1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ROT1;
        state_d       = S_ROT2;
      end
      S_ROT2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ROT2;
        cmd_o.rot_mid = 1'b1;
        state_d       = S_ROT3;
      end
      S_ROT3: begin
        cmd_o.rot_end = 1'b1;
        state_d       = S_MUL_A;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = (state_q == S_IDLE);

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("word emitted into an occupied output register");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !cmd_o.div_step && !cmd_o.cor_step && !cmd_o.emit)
    else $error("datapath busy while idle");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.emit_outer && stat_i.pair_last |=> (state_q == S_IDLE))
    else $error("final vertex did not end the arc");

endmodule

@@ sv/arc_vertex_strip_generator_unit.sv @@
// ----------------------------------------------------------------------------
// arc_vertex_strip_generator_unit
// Arc to triangle strip tessellator, one arc request at a time.
// ----------------------------------------------------------------------------
// An arc request yields 2*(segments+1) vertex words. The step angle comes
// from a one-bit-per-cycle divider, then one shared cordic runs twice, for
// the step angle and the start angle. Each arc point then passes through the
// single pair of multipliers for its inner and outer vertex, followed by a
// rotation update on every point but the final one. A new request is taken
// once the final vertex is in the output register.
module arc_vertex_strip_generator_unit #(
  parameter int ANGLE_BITS        = avsg_pkg::AngleBitsDef,
  parameter int CORDIC_ITERATIONS = avsg_pkg::CordicIterDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic [15:0]        start_angle_i,
  input  logic [16:0]        sweep_angle_i,
  input  logic [15:0]        radius_i,
  input  logic [15:0]        thickness_i,
  input  logic [4:0]         segment_count_i,
  input  logic               fan_mode_i,
  input  logic [31:0]        color_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] vertex_x_o,
  output logic signed [15:0] vertex_y_o,
  output logic [31:0]        vertex_color_o,
  output logic               last_vertex_o
);
  import avsg_pkg::*;

  avsg_cmd_t  cmd;
  avsg_stat_t stat;
  logic       idle;

  avsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .idle_o     (idle),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  avsg_dp #(
    .ANGLE_BITS        (ANGLE_BITS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .start_angle_i   (start_angle_i),
    .sweep_angle_i   (sweep_angle_i),
    .radius_i        (radius_i),
    .thickness_i     (thickness_i),
    .segment_count_i (segment_count_i),
    .fan_mode_i      (fan_mode_i),
    .color_i         (color_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vertex_x_o      (vertex_x_o),
    .vertex_y_o      (vertex_y_o),
    .vertex_color_o  (vertex_color_o),
    .last_vertex_o   (last_vertex_o)
  );

  assign in_stall_o = !idle;

endmodule

@@ tb/arc_vertex_strip_generator_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arc_vertex_strip_generator_unit_tb
// Checks the arc tessellator against a bit-exact predictor of its vertex
// strip: directed corner arcs, random arcs, random gaps on both sides, a
// long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module arc_vertex_strip_generator_unit_tb;

  import avsg_pkg::*;

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [31:0]        colour;
    logic               last;
  } vertex_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] center_x_i;
  logic signed [15:0] center_y_i;
  logic [15:0]        start_angle_i;
  logic [16:0]        sweep_angle_i;
  logic [15:0]        radius_i;
  logic [15:0]        thickness_i;
  logic [4:0]         segment_count_i;
  logic               fan_mode_i;
  logic [31:0]        color_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] vertex_x_o;
  logic signed [15:0] vertex_y_o;
  logic [31:0]        vertex_color_o;
  logic               last_vertex_o;

  vertex_t pending_vertices[$];
  int      mismatch_cnt;
  int      hold_off_cycles;
  bit      timed_out;

  arc_vertex_strip_generator_unit DUT (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp16(longint v);
    return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
  endfunction

  function automatic longint round_q15(longint p);
    return floor_shr(p + 16384, 15);
  endfunction

  function automatic longint atan_turn(int i);
    longint t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                      21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                      333772, 166886, 83443, 41722, 20861};
    return t[i];
  endfunction

  task automatic sin_cos(input logic [15:0] ang, output longint s, output longint c);
    longint x, y, z, dx, dy, cr, sr;
    logic [1:0] quad;
    x = 652032874;
    y = 0;
    quad = ang[15:14];
    z = longint'(ang[13:0]) <<< 16;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_turn(i);
      end else begin
        x += dx; y -= dy; z += atan_turn(i);
      end
    end
    cr = clamp16(floor_shr(x + 16384, 15));
    sr = clamp16(floor_shr(y + 16384, 15));
    case (quad)
      2'd0: begin c = cr;  s = sr;  end
      2'd1: begin c = -sr; s = cr;  end
      2'd2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
  endtask

  // builds the expected vertex strip of one arc
  task automatic predict_strip(input logic signed [15:0] cx, cy, input logic [15:0] st,
                               input logic [16:0] sw, input logic [15:0] rad, thk,
                               input logic [4:0] segs, input logic fan,
                               input logic [31:0] col);
    longint ss, cs, sa, ca, ns, nc, r_in, r_out, n, total, k;
    vertex_t v;
    n = segs == 0 ? 1 : segs;
    total = (n + 1) * 2;
    k = 0;
    sin_cos(16'(sw / n), ss, cs);
    sin_cos(st, sa, ca);
    r_in = fan ? 0 : longint'(rad) - longint'(thk >> 1);
    r_out = fan ? longint'(rad) : longint'(rad) + longint'(thk >> 1);
    for (longint i = 0; i <= n; i++) begin
      v.colour = col;
      v.last = 1'b0;
      v.vx = 16'(clamp16(cx + round_q15(r_in * ca)));
      v.vy = 16'(clamp16(cy + round_q15(r_in * sa)));
      pending_vertices.push_back(v);
      k++;
      v.vx = 16'(clamp16(cx + round_q15(r_out * ca)));
      v.vy = 16'(clamp16(cy + round_q15(r_out * sa)));
      v.last = (k == total - 1);
      pending_vertices.push_back(v);
      k++;
      ns = clamp16(round_q15(sa * cs + ca * ss));
      nc = clamp16(round_q15(ca * cs - sa * ss));
      sa = ns;
      ca = nc;
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clk_i);
  endtask

  // offers one arc and waits for it to be taken
  task automatic send_arc(input logic signed [15:0] cx, cy, input logic [15:0] st,
                          input logic [16:0] sw, input logic [15:0] rad, thk,
                          input logic [4:0] segs, input logic fan,
                          input logic [31:0] col, input bit gaps = 1'b1);
    if (gaps) random_gap();
    center_x_i <= cx;
    center_y_i <= cy;
    start_angle_i <= st;
    sweep_angle_i <= sw;
    radius_i <= rad;
    thickness_i <= thk;
    segment_count_i <= segs;
    fan_mode_i <= fan;
    color_i <= col;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_strip(cx, cy, st, sw, rad, thk, segs, fan, col);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // the next word is driven no earlier than the following falling edge
    @(negedge clk_i);
  endtask

  task automatic send_random_arc(input bit gaps = 1'b1);
    logic [4:0] segs;
    logic [16:0] sw;
    segs = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
           5'($urandom_range(1, 6));
    case ($urandom_range(0, 3))
      0: sw = 17'($urandom_range(0, 65536));
      1: sw = 17'd65536;
      2: sw = 17'($urandom_range(65537, 131071));
      default: sw = 17'($urandom_range(0, 8192));
    endcase
    send_arc(16'($urandom), 16'($urandom), 16'($urandom), sw,
             ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000)),
             16'($urandom), segs, 1'($urandom), $urandom, gaps);
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_arc(0, 0, 0, 17'd65536, 16'd1600, 16'd320, 5'd4, 1'b0, 32'hFF00FF00);
    send_arc(0, 0, 16'h4000, 17'd16384, 16'd1600, 0, 5'd1, 1'b1, 32'h12345678);
    send_arc(16'sh7FFF, 16'sh7FFF, 16'h8000, 17'd65536, 16'hFFFF, 16'hFFFF, 5'd31, 1'b0,
             32'hFFFFFFFF);
    send_arc(-16'sh8000, -16'sh8000, 16'hC000, 17'd0, 16'hFFFF, 16'h0000, 5'd0, 1'b1, 0);
    send_arc(100, -100, 16'hFFFF, 17'h1FFFF, 16'd50, 16'hFFFF, 5'd3, 1'b0, 32'hA5A5A5A5);
    send_arc(-100, 100, 16'h2000, 17'd98304, 16'd0, 16'd7, 5'd7, 1'b1, 32'h5A5A5A5A);
    send_arc(16'sh1234, 16'sh4321, 16'h6000, 17'd32768, 16'd4000, 16'd1, 5'd16, 1'b0,
             32'h0F0F0F0F);
    send_arc(0, 0, 16'hE000, 17'd1, 16'd20000, 16'd50000, 5'd2, 1'b0, 32'hF0F0F0F0);
    wait_drained();
  endtask

  task automatic test_random_arcs();
    repeat (430) send_random_arc();
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    hold_off_cycles = 400;
    repeat (15) send_random_arc(1'b0);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (10) begin
      send_random_arc();
      wait_drained();
    end
  endtask

  // receiver stall: random gaps, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 25);
    end
  end

  // vertex checker
  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_vertices.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected vertex word x=%0d y=%0d",
                                         vertex_x_o, vertex_y_o);
      end else begin
        want = pending_vertices.pop_front();
        if (vertex_x_o !== want.vx || vertex_y_o !== want.vy ||
            vertex_color_o !== want.colour || last_vertex_o !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("vertex mismatch: exp x=%0d y=%0d c=%h l=%b got x=%0d y=%0d c=%h l=%b",
                     want.vx, want.vy, want.colour, want.last, vertex_x_o, vertex_y_o,
                     vertex_color_o, last_vertex_o);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    mismatch_cnt = 0;
    hold_off_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    center_x_i = '0;
    center_y_i = '0;
    start_angle_i = '0;
    sweep_angle_i = '0;
    radius_i = '0;
    thickness_i = '0;
    segment_count_i = '0;
    fan_mode_i = 1'b0;
    color_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_output_hold_off();
    test_drain_pause();
    test_random_arcs();
    repeat (300) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_vertices.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
